### hw/rtl/gpm_pkg.sv
// Shared types and constants for the GPIO pin mux and pad register unit.
// No dependencies; every other file in this block imports it.
package gpm_pkg;

    // Width of the pin-wide ports, fixed by the bus map.
    localparam int FIELD_W = 54;

    // Access kind and bank select codes.
    localparam logic MODE_READ    = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;
    localparam logic REGION_GPIO  = 1'b0;
    localparam logic REGION_PAD   = 1'b1;

    // GPIO bank word offsets (function select words start at zero).
    localparam logic [5:0] OFF_SET0      = 6'd7;
    localparam logic [5:0] OFF_SET1      = 6'd8;
    localparam logic [5:0] OFF_CLR0      = 6'd10;
    localparam logic [5:0] OFF_CLR1      = 6'd11;
    localparam logic [5:0] OFF_LEV0      = 6'd13;
    localparam logic [5:0] OFF_LEV1      = 6'd14;
    localparam logic [5:0] OFF_PULL_CTL  = 6'd37;
    localparam logic [5:0] OFF_PULL_CLK0 = 6'd38;
    localparam logic [5:0] OFF_PULL_CLK1 = 6'd39;

    // Pad bank word offsets.
    localparam logic [5:0] OFF_PAD_LOW   = 6'd11;
    localparam logic [5:0] OFF_PAD_HIGH  = 6'd12;

    // Pad writes need this key in the top byte of the data.
    localparam logic [7:0] PAD_KEY   = 8'h5A;
    localparam logic [4:0] PAD_RESET = 5'd27;

    // Pin function and pull codes.
    localparam logic [2:0] FUNC_OUTPUT = 3'd1;
    localparam logic [1:0] PULL_DOWN   = 2'b01;
    localparam logic [1:0] PULL_UP     = 2'b10;

    // One bus access as it travels from the input register to the register file.
    typedef struct packed {
        logic               mode;
        logic               region;
        logic [5:0]         word_offset;
        logic [31:0]        write_data;
        logic [FIELD_W-1:0] pin_levels;
    } req_t;

    // One result item, with the pin state after the access.
    typedef struct packed {
        logic [31:0]        read_data;
        logic               status;
        logic [FIELD_W-1:0] output_enable;
        logic [FIELD_W-1:0] output_level;
        logic [FIELD_W-1:0] pull_up_mask;
        logic [FIELD_W-1:0] pull_down_mask;
        logic [4:0]         pad_group_low;
        logic [4:0]         pad_group_high;
    } rsp_t;

endpackage

### hw/rtl/gpio_pin_mux_and_pad_registers_unit.sv
// Top level of the GPIO pin mux and pad register unit.
// Depends on gpm_pkg, gpm_in_stage, gpm_regs and gpm_out_stage.
//
// Usage:
//   Each input item is one bus access (mode, region, word_offset, write_data)
//   together with the sampled pin levels. Each item yields exactly one result
//   item: read data, an unmapped-offset status bit, and the full pin state
//   (output enables, output latch, pull masks, pad words) after the access.
//   Both channels use valid/stall; an item moves at a clock edge where valid
//   is high and stall is low.
// Data path:
//   The accepting edge loads the input register; once the result register
//   can take the item, it passes through the decode logic into the result
//   register, which then offers it. One item per cycle is sustained while
//   the receiver does not stall; the access decode and the per-pin update are
//   a single pass of logic between those two registers.
// Reset:
//   All pins are inputs, the latch and pull state are zero and both pad words
//   read 27. Both registers come up empty.
// Stalls:
//   While the receiver stalls, the result register holds its item; the input
//   register still takes one more item and then raises in_stall.
module gpio_pin_mux_and_pad_registers_unit
    import gpm_pkg::*;
#(
    parameter int NUM_PINS = 54
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic               region,
    input  logic [5:0]         word_offset,
    input  logic [31:0]        write_data,
    input  logic [FIELD_W-1:0] pin_levels,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        read_data,
    output logic               status,
    output logic [FIELD_W-1:0] output_enable,
    output logic [FIELD_W-1:0] output_level,
    output logic [FIELD_W-1:0] pull_up_mask,
    output logic [FIELD_W-1:0] pull_down_mask,
    output logic [4:0]         pad_group_low,
    output logic [4:0]         pad_group_high
);

    req_t in_req;
    req_t req;
    rsp_t rsp_next;
    rsp_t rsp;
    logic fire;
    logic down_ready;

    // Gather the input ports into one item.
    always_comb
    begin
        in_req.mode        = mode;
        in_req.region      = region;
        in_req.word_offset = word_offset;
        in_req.write_data  = write_data;
        in_req.pin_levels  = pin_levels;
    end

    gpm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_req     (in_req),
        .down_ready (down_ready),
        .fire       (fire),
        .req        (req)
    );

    gpm_regs #(
        .NUM_PINS (NUM_PINS)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req),
        .rsp   (rsp_next)
    );

    gpm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .rsp_in    (rsp_next),
        .up_ready  (down_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rsp       (rsp)
    );

    // Spread the result item onto the output ports.
    assign read_data      = rsp.read_data;
    assign status         = rsp.status;
    assign output_enable  = rsp.output_enable;
    assign output_level   = rsp.output_level;
    assign pull_up_mask   = rsp.pull_up_mask;
    assign pull_down_mask = rsp.pull_down_mask;
    assign pad_group_low  = rsp.pad_group_low;
    assign pad_group_high = rsp.pad_group_high;

    // A held result is never overwritten while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !fire)
    else $error("result register overwritten during a stall");

endmodule

### hw/rtl/gpm_in_stage.sv
// Input register of the GPIO pin mux unit: captures one bus access per item.
// Depends on gpm_pkg for the request type.
module gpm_in_stage
    import gpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_req,
    input  logic down_ready,
    output logic fire,
    output req_t req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic accept;

    // The held item moves on whenever the result register can take it.
    assign fire     = valid_reg && down_ready;
    assign in_stall = valid_reg && !down_ready;
    assign accept   = in_valid && !in_stall;
    assign req      = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    // Control bit with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on acceptance only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_req;
        end
    end

endmodule

### hw/rtl/gpm_regs.sv
// Register file of the GPIO pin mux unit: access decode, pin state and result.
// Depends on gpm_pkg for the request and result types and the register map.
module gpm_regs
    import gpm_pkg::*;
#(
    parameter int NUM_PINS = 54
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t req,
    output rsp_t rsp
);

    localparam int FSEL_WORDS = (NUM_PINS + 9) / 10;
    localparam logic [63:0] PIN_MASK64 =
        (NUM_PINS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_PINS) - 64'd1);

    // Pin state.
    logic [2:0]          func_reg  [NUM_PINS];
    logic [2:0]          func_next [NUM_PINS];
    logic [1:0]          pull_reg  [NUM_PINS];
    logic [1:0]          pull_next [NUM_PINS];
    logic [NUM_PINS-1:0] latch_reg;
    logic [NUM_PINS-1:0] latch_next;
    logic [1:0]          pull_sel_reg;
    logic [1:0]          pull_sel_next;
    logic [4:0]          pad_low_reg;
    logic [4:0]          pad_low_next;
    logic [4:0]          pad_high_reg;
    logic [4:0]          pad_high_next;

    // Decode results.
    logic                is_write;
    logic                key_ok;
    logic                fsel_hit;
    logic                fsel_wr;
    logic                set_wr;
    logic                clr_wr;
    logic                pull_ctl_wr;
    logic                pull_clk_wr;
    logic                pad_low_wr;
    logic                pad_high_wr;
    logic                hi_word;
    logic [31:0]         rd;
    logic                status;
    logic [31:0]         fsel_rd;
    logic [63:0]         lev64;
    logic [63:0]         data64;
    logic [NUM_PINS-1:0] data_pins;
    logic [63:0]         oe64;
    logic [63:0]         pu64;
    logic [63:0]         pd64;
    logic [63:0]         latch64;

    // Data word placed on the low or high 32 pins, and masked pin levels.
    assign data64    = hi_word ? {req.write_data, 32'd0} : {32'd0, req.write_data};
    assign data_pins = data64[NUM_PINS-1:0];
    assign lev64     = {{(64 - FIELD_W){1'b0}}, req.pin_levels} & PIN_MASK64;
    assign is_write  = (req.mode == MODE_WRITE);
    assign key_ok    = (req.write_data[31:24] == PAD_KEY);
    assign fsel_hit  = (req.region == REGION_GPIO) && (req.word_offset < 6'(FSEL_WORDS));

    // Function select read: up to ten 3-bit fields of the addressed word.
    always_comb
    begin
        fsel_rd = 32'd0;
        for (int n = 0; n < NUM_PINS; n++)
        begin
            if (req.word_offset == 6'(n / 10))
            begin
                fsel_rd[3 * (n % 10) +: 3] = func_reg[n];
            end
        end
    end

    // Access decode; function select words take precedence over the fixed map.
    always_comb
    begin
        fsel_wr     = 1'b0;
        set_wr      = 1'b0;
        clr_wr      = 1'b0;
        pull_ctl_wr = 1'b0;
        pull_clk_wr = 1'b0;
        pad_low_wr  = 1'b0;
        pad_high_wr = 1'b0;
        hi_word     = 1'b0;
        rd          = 32'd0;
        status      = 1'b0;
        priority if (req.region == REGION_PAD)
        begin
            unique case (req.word_offset)
                OFF_PAD_LOW:
                begin
                    pad_low_wr = is_write && key_ok;
                    rd         = is_write ? 32'd0 : 32'(pad_low_reg);
                end
                OFF_PAD_HIGH:
                begin
                    pad_high_wr = is_write && key_ok;
                    rd          = is_write ? 32'd0 : 32'(pad_high_reg);
                end
                default:
                begin
                    status = 1'b1;
                end
            endcase
        end
        else if (fsel_hit)
        begin
            fsel_wr = is_write;
            rd      = is_write ? 32'd0 : fsel_rd;
        end
        else
        begin
            unique case (req.word_offset)
                OFF_SET0, OFF_SET1:
                begin
                    set_wr  = is_write;
                    hi_word = (req.word_offset == OFF_SET1);
                end
                OFF_CLR0, OFF_CLR1:
                begin
                    clr_wr  = is_write;
                    hi_word = (req.word_offset == OFF_CLR1);
                end
                OFF_LEV0, OFF_LEV1:
                begin
                    if (!is_write)
                    begin
                        rd = (req.word_offset == OFF_LEV1) ? lev64[63:32] : lev64[31:0];
                    end
                end
                OFF_PULL_CTL:
                begin
                    pull_ctl_wr = is_write;
                    rd          = is_write ? 32'd0 : 32'(pull_sel_reg);
                end
                OFF_PULL_CLK0, OFF_PULL_CLK1:
                begin
                    pull_clk_wr = is_write;
                    hi_word     = (req.word_offset == OFF_PULL_CLK1);
                end
                default:
                begin
                    status = 1'b1;
                end
            endcase
        end
    end

    // Next state of the latch, pull select and pad words.
    always_comb
    begin
        latch_next = latch_reg;
        if (set_wr)
        begin
            latch_next = latch_reg | data_pins;
        end
        else if (clr_wr)
        begin
            latch_next = latch_reg & ~data_pins;
        end
        pull_sel_next = pull_ctl_wr ? req.write_data[1:0] : pull_sel_reg;
        pad_low_next  = pad_low_wr ? req.write_data[4:0] : pad_low_reg;
        pad_high_next = pad_high_wr ? req.write_data[4:0] : pad_high_reg;
    end

    // Per-pin next state and the pin masks seen after the access.
    always_comb
    begin
        oe64 = 64'd0;
        pu64 = 64'd0;
        pd64 = 64'd0;
        for (int n = 0; n < NUM_PINS; n++)
        begin
            func_next[n] = func_reg[n];
            if (fsel_wr && (req.word_offset == 6'(n / 10)))
            begin
                func_next[n] = req.write_data[3 * (n % 10) +: 3];
            end
            pull_next[n] = (pull_clk_wr && data_pins[n]) ? pull_sel_reg : pull_reg[n];
            oe64[n] = (func_next[n] == FUNC_OUTPUT);
            pu64[n] = (pull_next[n] == PULL_UP);
            pd64[n] = (pull_next[n] == PULL_DOWN);
        end
    end

    assign latch64 = 64'(latch_next);

    // Result item.
    always_comb
    begin
        rsp.read_data      = rd;
        rsp.status         = status;
        rsp.output_enable  = oe64[FIELD_W-1:0];
        rsp.output_level   = latch64[FIELD_W-1:0];
        rsp.pull_up_mask   = pu64[FIELD_W-1:0];
        rsp.pull_down_mask = pd64[FIELD_W-1:0];
        rsp.pad_group_low  = pad_low_next;
        rsp.pad_group_high = pad_high_next;
    end

    // State registers, updated once per item that passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_PINS; n++)
            begin
                func_reg[n] <= 3'd0;
                pull_reg[n] <= 2'd0;
            end
            latch_reg    <= '0;
            pull_sel_reg <= 2'd0;
            pad_low_reg  <= PAD_RESET;
            pad_high_reg <= PAD_RESET;
        end
        else if (fire)
        begin
            for (int n = 0; n < NUM_PINS; n++)
            begin
                func_reg[n] <= func_next[n];
                pull_reg[n] <= pull_next[n];
            end
            latch_reg    <= latch_next;
            pull_sel_reg <= pull_sel_next;
            pad_low_reg  <= pad_low_next;
            pad_high_reg <= pad_high_next;
        end
    end

    // A low pad word write without the key leaves that pad word alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.region == REGION_PAD) && is_write && !key_ok
        && (req.word_offset == OFF_PAD_LOW)
        |=> $stable(pad_low_reg))
    else $error("pad_low changed by a write without the key");

    // An unmapped access changes no state.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && status |=> $stable(latch_reg) && $stable(pull_sel_reg)
        && $stable(pad_low_reg) && $stable(pad_high_reg))
    else $error("state changed by an unmapped access");

    // Reads never move the output latch.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !is_write |=> $stable(latch_reg))
    else $error("output latch changed by a read");

    // Write-only words and writes return zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_write |-> (rd == 32'd0))
    else $error("write returned nonzero read data");

endmodule

### hw/rtl/gpm_out_stage.sv
// Result register of the GPIO pin mux unit: holds one item until it is taken.
// Depends on gpm_pkg for the result type.
module gpm_out_stage
    import gpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rsp_t rsp_in,
    output logic up_ready,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    // Free when empty or when the held item leaves this cycle.
    assign up_ready  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

endmodule
